FILE: rtl/core/csf_pkg.sv
// Shared types and constants for the camera scroll follower.
`default_nettype none

package csf_pkg;

  // Default geometry
  localparam int unsigned POS_BITS_DEF  = 24;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Configuration port
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned VIEW_W = 16;

  // Register reset values
  localparam logic [STEP_W-1:0] ACCEL_RST       = 16'd256;
  localparam logic [STEP_W-1:0] DECEL_RST       = 16'd256;
  localparam int unsigned       SPEED_LIMIT_RST = 2560;
  localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = 16'd640;
  localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = 16'd480;

  // Side-band widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned MOVE_W = 2;
  localparam int unsigned USER_W = ACT_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_SNAP = 2'd1,
    ACT_LOAD = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_ACCEL       = 3'd0,
    REG_DECEL       = 3'd1,
    REG_SPEED_LIMIT = 3'd2,
    REG_VIEW_WIDTH  = 3'd3,
    REG_VIEW_HEIGHT = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: rtl/core/camera_scroll_follower.sv
// Camera scroll follower: viewport pos and velocity, one word per unstalled cycle.
`default_nettype none

// Keeps a viewport corner (whole pixels) and a per-axis velocity (FRAC_BITS
// fractional bits) and updates them for every input word. tuser carries the
// action: a tick moves the view, following the target (velocity = a quarter
// of the offset from the centred position, nothing below one pixel) or under
// manual push (accelerate, brake on reversal, coast to rest, limit to
// speed_limit), then steps by the velocity truncated towards zero and clamps
// to the world bounds; snap centres the view on the target; load sets the
// corner and stops the camera; action code 3 leaves everything alone. Each
// accepted word gives exactly one result word carrying the new corner, the
// corner before the last tick and the velocity. Throughput is one word per
// clock: the whole update is a single combinational pass from the state
// registers, which double as the output register; the result is registered
// on acceptance, and a new word is taken in the same cycle as the previous
// result is taken. s_axis_tready only drops while a result is held back by
// m_axis_tready. Write registers over the APB port only while the block is
// idle (unenforced); all arithmetic saturates to the signed POS_BITS range.
module camera_scroll_follower
  import csf_pkg::*;
#(
  parameter int unsigned POS_BITS  = POS_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned IN_W  = ((2 * MOVE_W + 6 * POS_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((6 * POS_BITS + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  // Input words
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // move_x, move_y, target_x, target_y, bound_left, bound_right,
  // bound_bottom, bound_top (zero padded)
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  // action, follow_target
  input  wire logic [USER_W-1:0] s_axis_tuser,

  // Result words
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // pos_x, pos_y, prev_x, prev_y, vel_x, vel_y (zero padded)
  output logic [OUT_W-1:0]       m_axis_tdata,

  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // Internal width: room for offsets, shifted offsets and added steps
  localparam int unsigned XW = POS_BITS + FRAC_BITS + 20;
  localparam int unsigned LIM_W = POS_BITS - 1;

  typedef logic signed [XW-1:0]       xw_t;
  typedef logic signed [POS_BITS-1:0] pos_t;

  localparam xw_t X_HI = xw_t'({1'b0, {LIM_W{1'b1}}});
  localparam xw_t X_LO = -X_HI - xw_t'(1);
  localparam xw_t X_FOUR = xw_t'(4);

  // Field offsets in s_axis_tdata
  localparam int unsigned OFS_MY = MOVE_W;
  localparam int unsigned OFS_TX = 2 * MOVE_W;
  localparam int unsigned OFS_TY = OFS_TX + POS_BITS;
  localparam int unsigned OFS_BL = OFS_TY + POS_BITS;
  localparam int unsigned OFS_BR = OFS_BL + POS_BITS;
  localparam int unsigned OFS_BB = OFS_BR + POS_BITS;
  localparam int unsigned OFS_BT = OFS_BB + POS_BITS;

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------
  function automatic pos_t sat_p(xw_t v);
    pos_t r;
    if (v > X_HI) begin
      r = X_HI[POS_BITS-1:0];
    end else if (v < X_LO) begin
      r = X_LO[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  function automatic xw_t half_of(logic [VIEW_W-1:0] view);
    return xw_t'({1'b0, view[VIEW_W-1:1]});
  endfunction

  function automatic pos_t follow_vel(pos_t tgt, logic [VIEW_W-1:0] view, pos_t cam);
    xw_t  off;
    pos_t r;
    off = xw_t'(tgt) - half_of(view) - xw_t'(cam);
    // offset under four pixels (sub-pixel velocity): hold still
    if (off > -X_FOUR && off < X_FOUR) begin
      r = '0;
    end else begin
      r = sat_p(off <<< (FRAC_BITS - 2));
    end
    return r;
  endfunction

  function automatic pos_t manual_vel(pos_t vel, logic [MOVE_W-1:0] mv,
                                      logic [STEP_W-1:0] acc,
                                      logic [STEP_W-1:0] dec,
                                      logic [LIM_W-1:0] lim);
    xw_t v;
    xw_t a;
    xw_t d;
    xw_t l;
    v = xw_t'(vel);
    a = xw_t'({1'b0, acc});
    d = xw_t'({1'b0, dec});
    l = xw_t'({1'b0, lim});
    if (mv == '0) begin
      // coast towards rest, no limit applied
      if (v < 0) begin
        v = v + d;
        if (v > 0) v = '0;
      end else if (v > 0) begin
        v = v - d;
        if (v < 0) v = '0;
      end
    end else begin
      if (mv[MOVE_W-1]) begin
        v = (v > 0) ? v - d : v - a;
      end else begin
        v = (v < 0) ? v + d : v + a;
      end
      if (v < -l) begin
        v = -l;
      end else if (v > l) begin
        v = l;
      end
    end
    return sat_p(v);
  endfunction

  // Truncate towards zero to whole pixels
  function automatic xw_t whole_px(pos_t vel);
    xw_t v;
    xw_t r;
    v = xw_t'(vel);
    if (v >= 0) begin
      r = v >>> FRAC_BITS;
    end else begin
      r = -((-v) >>> FRAC_BITS);
    end
    return r;
  endfunction

  // x: lower bound first, upper bound wins
  function automatic pos_t step_x(pos_t cam, pos_t vel, pos_t lo, pos_t hi_edge,
                                  logic [VIEW_W-1:0] view);
    xw_t n;
    xw_t hi;
    n  = xw_t'(cam) + whole_px(vel);
    hi = xw_t'(hi_edge) - xw_t'({1'b0, view});
    if (n < xw_t'(lo)) n = xw_t'(lo);
    if (n > hi) n = hi;
    return sat_p(n);
  endfunction

  // y: upper bound first, lower bound wins
  function automatic pos_t step_y(pos_t cam, pos_t vel, pos_t lo, pos_t hi_edge,
                                  logic [VIEW_W-1:0] view);
    xw_t n;
    xw_t hi;
    n  = xw_t'(cam) + whole_px(vel);
    hi = xw_t'(hi_edge) - xw_t'({1'b0, view});
    if (n > hi) n = hi;
    if (n < xw_t'(lo)) n = xw_t'(lo);
    return sat_p(n);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] accel_q;
  logic [STEP_W-1:0] decel_q;
  logic [LIM_W-1:0]  speed_limit_q;
  logic [VIEW_W-1:0] view_width_q;
  logic [VIEW_W-1:0] view_height_q;
  logic              cfg_wr;
  cfg_reg_e          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_e'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q       <= ACCEL_RST;
      decel_q       <= DECEL_RST;
      speed_limit_q <= LIM_W'(SPEED_LIMIT_RST);
      view_width_q  <= VIEW_WIDTH_RST;
      view_height_q <= VIEW_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ACCEL:       accel_q       <= pwdata[STEP_W-1:0];
        REG_DECEL:       decel_q       <= pwdata[STEP_W-1:0];
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[LIM_W-1:0];
        REG_VIEW_WIDTH:  view_width_q  <= pwdata[VIEW_W-1:0];
        REG_VIEW_HEIGHT: view_height_q <= pwdata[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ACCEL:       prdata = CFG_DW'(accel_q);
      REG_DECEL:       prdata = CFG_DW'(decel_q);
      REG_SPEED_LIMIT: prdata = CFG_DW'(speed_limit_q);
      REG_VIEW_WIDTH:  prdata = CFG_DW'(view_width_q);
      REG_VIEW_HEIGHT: prdata = CFG_DW'(view_height_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input word fields
  // ---------------------------------------------------------------------------
  action_e           in_act;
  logic              in_follow;
  logic [MOVE_W-1:0] in_mx;
  logic [MOVE_W-1:0] in_my;
  pos_t              in_tx;
  pos_t              in_ty;
  pos_t              in_bl;
  pos_t              in_br;
  pos_t              in_bb;
  pos_t              in_bt;

  assign in_act    = action_e'(s_axis_tuser[ACT_W-1:0]);
  assign in_follow = s_axis_tuser[ACT_W];
  assign in_mx     = s_axis_tdata[MOVE_W-1:0];
  assign in_my     = s_axis_tdata[OFS_MY +: MOVE_W];
  assign in_tx     = s_axis_tdata[OFS_TX +: POS_BITS];
  assign in_ty     = s_axis_tdata[OFS_TY +: POS_BITS];
  assign in_bl     = s_axis_tdata[OFS_BL +: POS_BITS];
  assign in_br     = s_axis_tdata[OFS_BR +: POS_BITS];
  assign in_bb     = s_axis_tdata[OFS_BB +: POS_BITS];
  assign in_bt     = s_axis_tdata[OFS_BT +: POS_BITS];

  // ---------------------------------------------------------------------------
  // State update: the state registers are also the result register
  // ---------------------------------------------------------------------------
  pos_t cam_x_q,  cam_x_d;
  pos_t cam_y_q,  cam_y_d;
  pos_t last_x_q, last_x_d;
  pos_t last_y_q, last_y_d;
  pos_t vel_x_q,  vel_x_d;
  pos_t vel_y_q,  vel_y_d;
  logic out_valid_q;
  logic in_acc;

  always_comb begin
    cam_x_d  = cam_x_q;
    cam_y_d  = cam_y_q;
    last_x_d = last_x_q;
    last_y_d = last_y_q;
    vel_x_d  = vel_x_q;
    vel_y_d  = vel_y_q;
    case (in_act)
      ACT_TICK: begin
        if (in_follow) begin
          vel_x_d = follow_vel(in_tx, view_width_q, cam_x_q);
          vel_y_d = follow_vel(in_ty, view_height_q, cam_y_q);
        end else begin
          vel_x_d = manual_vel(vel_x_q, in_mx, accel_q, decel_q, speed_limit_q);
          vel_y_d = manual_vel(vel_y_q, in_my, accel_q, decel_q, speed_limit_q);
        end
        last_x_d = cam_x_q;
        last_y_d = cam_y_q;
        cam_x_d  = step_x(cam_x_q, vel_x_d, in_bl, in_br, view_width_q);
        cam_y_d  = step_y(cam_y_q, vel_y_d, in_bb, in_bt, view_height_q);
      end
      ACT_SNAP: begin
        cam_x_d = sat_p(xw_t'(in_tx) - half_of(view_width_q));
        cam_y_d = sat_p(xw_t'(in_ty) - half_of(view_height_q));
      end
      ACT_LOAD: begin
        cam_x_d = in_tx;
        cam_y_d = in_ty;
        vel_x_d = '0;
        vel_y_d = '0;
      end
      default: ; // unused code: report state unchanged
    endcase
  end

  // Take a word whenever the held result is gone or leaves this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cam_x_q  <= cam_x_d;
        cam_y_q  <= cam_y_d;
        last_x_q <= last_x_d;
        last_y_q <= last_y_d;
        vel_x_q  <= vel_x_d;
        vel_y_q  <= vel_y_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({vel_y_q, vel_x_q, last_y_q, last_x_q, cam_y_q, cam_x_q});

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // A held result must never be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // Load stops the camera
  a_load_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_act == ACT_LOAD |=> vel_x_q == '0 && vel_y_q == '0)
    else $error("velocity not cleared by load");

  // A tick records the corner it started from
  a_tick_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_act == ACT_TICK
    |=> last_x_q == $past(cam_x_q) && last_y_q == $past(cam_y_q))
    else $error("previous corner not recorded");

  // Manual push keeps x speed within the limit
  a_manual_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_act == ACT_TICK && !in_follow && in_mx != '0
    |=> vel_x_q <= $signed({1'b0, $past(speed_limit_q)})
        && vel_x_q >= -$signed({1'b0, $past(speed_limit_q)}))
    else $error("manual velocity beyond limit");
`endif

endmodule

`default_nettype wire
